@@ sv/cfa_pkg.sv @@
// Shared widths, operation and status codes, and pipeline stage types
// for the complex fixed-point ALU. No dependencies.
`default_nettype none

package cfa_pkg;

  // Operand format: signed W-bit parts with FRAC fraction bits.
  localparam int W     = 16;
  localparam int FRAC  = 8;
  localparam int PW    = 2 * W;        // product width
  localparam int SW    = PW + 1;       // sum of two products
  localparam int REM_W = PW + FRAC;    // scaled dividend / remainder
  localparam int CW    = PW + W;       // divider compare width

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EQ  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
    logic                eq;
    logic [1:0]          status;
  } res_t;

  typedef struct packed {
    logic signed [W-1:0] val;
    logic                sat;
  } sat_t;

  // Stage 1: raw products plus the finished result for cheap operations
  typedef struct packed {
    logic                 is_mul;
    logic                 is_div;
    res_t                 fast;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic [PW-1:0]        sq_r;
    logic [PW-1:0]        sq_i;
  } s1_t;

  // Stage 2: divide numerators and divisor magnitude
  typedef struct packed {
    logic                 is_div;
    res_t                 fast;
    logic signed [SW-1:0] num_re;
    logic signed [SW-1:0] num_im;
    logic [PW-1:0]        den;
  } s2_t;

  // Divider stages: one quotient bit per part per stage
  typedef struct packed {
    logic             is_div;
    logic             dz;
    res_t             fast;
    logic             neg_re;
    logic             neg_im;
    logic             ovf_re;
    logic             ovf_im;
    logic [REM_W-1:0] rem_re;
    logic [REM_W-1:0] rem_im;
    logic [W-1:0]     q_re;
    logic [W-1:0]     q_im;
    logic [PW-1:0]    den;
  } dv_t;

endpackage

`default_nettype wire

@@ sv/complex_fixed_point_alu.sv @@
// Complex fixed-point ALU: add, subtract, multiply, divide and equality test
// on signed Q8.8 complex operands. Depends on cfa_pkg.
//
//   channel  | direction | handshake          | beat contents
//   ---------+-----------+--------------------+---------------------------------
//   in_      | input     | in_valid/in_ready  | kind, a_re, a_im, b_re, b_im
//   out_     | output    | out_valid/out_ready| res_re, res_im, equal_flag, status
//
// One item per cycle while out_ready holds high; the pipeline depth is set by
// the restoring divider, which retires one quotient bit per stage for each part.
// Every operation travels the full pipeline so results leave in input order.
// Reset (synchronous, active low) clears all stage valid bits.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// close up while out_ready is low and input is taken until the pipeline is full.
`default_nettype none

module complex_fixed_point_alu (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  in_kind,
  input  wire logic signed [cfa_pkg::W-1:0] in_a_re,
  input  wire logic signed [cfa_pkg::W-1:0] in_a_im,
  input  wire logic signed [cfa_pkg::W-1:0] in_b_re,
  input  wire logic signed [cfa_pkg::W-1:0] in_b_im,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [cfa_pkg::W-1:0]     out_res_re,
  output logic signed [cfa_pkg::W-1:0]     out_res_im,
  output logic                             out_equal_flag,
  output logic [1:0]                       out_status
);

  localparam int W     = cfa_pkg::W;
  localparam int FRAC  = cfa_pkg::FRAC;
  localparam int PW    = cfa_pkg::PW;
  localparam int SW    = cfa_pkg::SW;
  localparam int REM_W = cfa_pkg::REM_W;
  localparam int CW    = cfa_pkg::CW;

  localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;
  localparam logic [W-1:0] QMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] QHALF = {1'b1, {(W-1){1'b0}}};

  // Clamp a wide signed value into W bits
  function automatic cfa_pkg::sat_t sat_fn(input logic signed [SW-1:0] v);
    cfa_pkg::sat_t r;
    if (v > SMAX) begin
      r.val = QMAX;
      r.sat = 1'b1;
    end else if (v < SMIN) begin
      r.val = QHALF;
      r.sat = 1'b1;
    end else begin
      r.val = v[W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Apply sign to a quotient magnitude and clamp
  function automatic cfa_pkg::sat_t pack_fn(input logic neg, input logic ovf,
                                            input logic [W-1:0] q);
    cfa_pkg::sat_t r;
    if (ovf) begin
      r.val = neg ? QHALF : QMAX;
      r.sat = 1'b1;
    end else if (neg) begin
      if (q > QHALF) begin
        r.val = QHALF;
        r.sat = 1'b1;
      end else begin
        r.val = ~q + 1'b1;
        r.sat = 1'b0;
      end
    end else if (q > QMAX) begin
      r.val = QMAX;
      r.sat = 1'b1;
    end else begin
      r.val = q;
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Stage registers and valid bits
  logic           v1_r, v2_r, out_valid_r;
  logic [W:0]     vd_r;
  cfa_pkg::s1_t   s1_r, s1_nxt;
  cfa_pkg::s2_t   s2_r, s2_nxt;
  cfa_pkg::dv_t   dv_r [0:W];
  cfa_pkg::dv_t   dv0_nxt;
  cfa_pkg::dv_t   dv_nxt [1:W];
  cfa_pkg::res_t  out_r, out_nxt;

  // Load enables
  logic           rdy1, rdy2, rdy_o;
  logic [W:0]     rdy_d;

  always_comb begin
    rdy_o    = !out_valid_r || out_ready;
    rdy_d[W] = !vd_r[W] || rdy_o;
    for (int k = W - 1; k >= 0; k--) begin
      rdy_d[k] = !vd_r[k] || rdy_d[k+1];
    end
    rdy2 = !v2_r || rdy_d[0];
    rdy1 = !v1_r || rdy2;
  end

  assign in_ready = rdy1;

  // Stage 1: products, add/subtract and compare
  logic signed [W:0] add_re, add_im;
  cfa_pkg::sat_t     sa_re, sa_im;

  always_comb begin
    if (in_kind == cfa_pkg::OP_SUB) begin
      add_re = {in_a_re[W-1], in_a_re} - {in_b_re[W-1], in_b_re};
      add_im = {in_a_im[W-1], in_a_im} - {in_b_im[W-1], in_b_im};
    end else begin
      add_re = {in_a_re[W-1], in_a_re} + {in_b_re[W-1], in_b_re};
      add_im = {in_a_im[W-1], in_a_im} + {in_b_im[W-1], in_b_im};
    end
    sa_re = sat_fn({{(SW-W-1){add_re[W]}}, add_re});
    sa_im = sat_fn({{(SW-W-1){add_im[W]}}, add_im});

    s1_nxt.is_mul      = (in_kind == cfa_pkg::OP_MUL);
    s1_nxt.is_div      = (in_kind == cfa_pkg::OP_DIV);
    s1_nxt.fast.re     = '0;
    s1_nxt.fast.im     = '0;
    s1_nxt.fast.eq     = 1'b0;
    s1_nxt.fast.status = cfa_pkg::ST_OK;
    case (in_kind)
      cfa_pkg::OP_ADD, cfa_pkg::OP_SUB: begin
        s1_nxt.fast.re     = sa_re.val;
        s1_nxt.fast.im     = sa_im.val;
        s1_nxt.fast.status = (sa_re.sat || sa_im.sat) ? cfa_pkg::ST_SAT : cfa_pkg::ST_OK;
      end
      cfa_pkg::OP_EQ: begin
        s1_nxt.fast.eq = (in_a_re == in_b_re) && (in_a_im == in_b_im);
      end
      default: begin
      end
    endcase

    s1_nxt.p_rr = in_a_re * in_b_re;
    s1_nxt.p_ii = in_a_im * in_b_im;
    s1_nxt.p_ri = in_a_re * in_b_im;
    s1_nxt.p_ir = in_a_im * in_b_re;
    s1_nxt.sq_r = in_b_re * in_b_re;
    s1_nxt.sq_i = in_b_im * in_b_im;
  end

  // Stage 2: product sums, multiply result, divide numerators and divisor
  logic signed [SW-1:0] e_rr, e_ii, e_ri, e_ir, m_re, m_im, sh_re, sh_im;
  cfa_pkg::sat_t        sm_re, sm_im;

  always_comb begin
    e_rr  = {s1_r.p_rr[PW-1], s1_r.p_rr};
    e_ii  = {s1_r.p_ii[PW-1], s1_r.p_ii};
    e_ri  = {s1_r.p_ri[PW-1], s1_r.p_ri};
    e_ir  = {s1_r.p_ir[PW-1], s1_r.p_ir};
    m_re  = e_rr - e_ii;
    m_im  = e_ri + e_ir;
    // arithmetic shift rounds toward minus infinity
    sh_re = m_re >>> FRAC;
    sh_im = m_im >>> FRAC;
    sm_re = sat_fn(sh_re);
    sm_im = sat_fn(sh_im);

    s2_nxt.is_div = s1_r.is_div;
    s2_nxt.fast   = s1_r.fast;
    if (s1_r.is_mul) begin
      s2_nxt.fast.re     = sm_re.val;
      s2_nxt.fast.im     = sm_im.val;
      s2_nxt.fast.status = (sm_re.sat || sm_im.sat) ? cfa_pkg::ST_SAT : cfa_pkg::ST_OK;
    end
    s2_nxt.num_re = e_rr + e_ii;
    s2_nxt.num_im = e_ir - e_ri;
    s2_nxt.den    = s1_r.sq_r + s1_r.sq_i;
  end

  // Stage 3: sign/magnitude split, scale, overflow check (quotient >= 2^W)
  logic [SW-1:0]    abs_re, abs_im;
  logic [REM_W-1:0] rem0_re, rem0_im;
  logic [CW-1:0]    den_top;

  always_comb begin
    abs_re  = s2_r.num_re[SW-1] ? (~s2_r.num_re + 1'b1) : s2_r.num_re;
    abs_im  = s2_r.num_im[SW-1] ? (~s2_r.num_im + 1'b1) : s2_r.num_im;
    rem0_re = {abs_re[PW-1:0], {FRAC{1'b0}}};
    rem0_im = {abs_im[PW-1:0], {FRAC{1'b0}}};
    den_top = {s2_r.den, {W{1'b0}}};

    dv0_nxt.is_div = s2_r.is_div;
    dv0_nxt.dz     = (s2_r.den == '0);
    dv0_nxt.fast   = s2_r.fast;
    dv0_nxt.neg_re = s2_r.num_re[SW-1];
    dv0_nxt.neg_im = s2_r.num_im[SW-1];
    dv0_nxt.ovf_re = {{(CW-REM_W){1'b0}}, rem0_re} >= den_top;
    dv0_nxt.ovf_im = {{(CW-REM_W){1'b0}}, rem0_im} >= den_top;
    dv0_nxt.rem_re = rem0_re;
    dv0_nxt.rem_im = rem0_im;
    dv0_nxt.q_re   = '0;
    dv0_nxt.q_im   = '0;
    dv0_nxt.den    = s2_r.den;
  end

  // Divider stages: stage k+1 tries divisor << (W-1-k)
  logic [CW-1:0] dsh;
  logic [CW:0]   t_re, t_im;

  always_comb begin
    dsh  = '0;
    t_re = '0;
    t_im = '0;
    for (int k = 0; k < W; k++) begin
      dv_nxt[k+1] = dv_r[k];
      dsh  = {dv_r[k].den, {W{1'b0}}} >> (k + 1);
      t_re = {{(CW-REM_W+1){1'b0}}, dv_r[k].rem_re} - {1'b0, dsh};
      t_im = {{(CW-REM_W+1){1'b0}}, dv_r[k].rem_im} - {1'b0, dsh};
      // keep the difference only when no borrow
      if (!t_re[CW]) begin
        dv_nxt[k+1].rem_re = t_re[REM_W-1:0];
      end
      if (!t_im[CW]) begin
        dv_nxt[k+1].rem_im = t_im[REM_W-1:0];
      end
      dv_nxt[k+1].q_re = {dv_r[k].q_re[W-2:0], !t_re[CW]};
      dv_nxt[k+1].q_im = {dv_r[k].q_im[W-2:0], !t_im[CW]};
    end
  end

  // Output stage: sign, clamp, select
  cfa_pkg::sat_t pk_re, pk_im;

  always_comb begin
    pk_re   = pack_fn(dv_r[W].neg_re, dv_r[W].ovf_re, dv_r[W].q_re);
    pk_im   = pack_fn(dv_r[W].neg_im, dv_r[W].ovf_im, dv_r[W].q_im);
    out_nxt = dv_r[W].fast;
    if (dv_r[W].is_div) begin
      out_nxt.eq = 1'b0;
      if (dv_r[W].dz) begin
        out_nxt.re     = '0;
        out_nxt.im     = '0;
        out_nxt.status = cfa_pkg::ST_DIVZ;
      end else begin
        out_nxt.re     = pk_re.val;
        out_nxt.im     = pk_im.val;
        out_nxt.status = (pk_re.sat || pk_im.sat) ? cfa_pkg::ST_SAT : cfa_pkg::ST_OK;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy_d[0]) begin
        vd_r[0] <= v2_r;
      end
      for (int k = 1; k <= W; k++) begin
        if (rdy_d[k]) begin
          vd_r[k] <= vd_r[k-1];
        end
      end
      if (rdy_o) begin
        out_valid_r <= vd_r[W];
      end
    end
  end

  // Payload: advance with the valid bits, hold on stall
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r <= s1_nxt;
    end
    if (rdy2) begin
      s2_r <= s2_nxt;
    end
    if (rdy_d[0]) begin
      dv_r[0] <= dv0_nxt;
    end
    for (int k = 1; k <= W; k++) begin
      if (rdy_d[k]) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
    if (rdy_o) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_res_re     = out_r.re;
  assign out_res_im     = out_r.im;
  assign out_equal_flag = out_r.eq;
  assign out_status     = out_r.status;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench for complex_fixed_point_alu: corner-case operand beats first, then random mixes.
// Each result is checked against a predictor of the complex arithmetic built into the bench.
// Depends on cfa_pkg and the ALU RTL.

module tb;

  localparam int W    = cfa_pkg::W;
  localparam int FRAC = cfa_pkg::FRAC;
  localparam logic [2:0] OP_LAST = 3'd7;  // codes above OP_EQ are unused
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 2 * W + 8;
  localparam int N_RANDOM     = 2000;

  typedef struct packed {
    logic [2:0]          kind;
    logic signed [W-1:0] a_re;
    logic signed [W-1:0] a_im;
    logic signed [W-1:0] b_re;
    logic signed [W-1:0] b_im;
  } alu_op_t;

  typedef struct packed {
    alu_op_t       op;
    cfa_pkg::res_t res;
  } alu_due_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          in_kind = cfa_pkg::OP_ADD;
  logic signed [W-1:0] in_a_re = '0;
  logic signed [W-1:0] in_a_im = '0;
  logic signed [W-1:0] in_b_re = '0;
  logic signed [W-1:0] in_b_im = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [W-1:0] out_res_re;
  logic signed [W-1:0] out_res_im;
  logic                out_equal_flag;
  logic [1:0]          out_status;

  alu_op_t  ops_to_send[$];
  alu_due_t results_due[$];
  int       mismatches = 0;
  int       beats_in = 0;
  int       beats_out = 0;
  int       idle_cycles = 0;
  int       send_gap = -1;
  int       recv_gap = -1;
  bit       hold_sender;

  complex_fixed_point_alu i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_a_re        (in_a_re),
    .in_a_im        (in_a_im),
    .in_b_re        (in_b_re),
    .in_b_im        (in_b_im),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_res_re     (out_res_re),
    .out_res_im     (out_res_im),
    .out_equal_flag (out_equal_flag),
    .out_status     (out_status)
  );

  // Clamp to the signed part range; flag any clamping.
  function automatic logic signed [W-1:0] sat_part(longint v, inout logic sat);
    longint hi;
    longint lo;
    hi = (longint'(1) << (W - 1)) - 1;
    lo = -(longint'(1) << (W - 1));
    if (v > hi) begin
      sat = 1'b1;
      v = hi;
    end else if (v < lo) begin
      sat = 1'b1;
      v = lo;
    end
    return v[W-1:0];
  endfunction

  // Scaled quotient, truncated toward zero.
  function automatic longint quot_trunc(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FRAC) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic cfa_pkg::res_t alu_expected(alu_op_t op);
    cfa_pkg::res_t r;
    logic          sat;
    longint        ar;
    longint        ai;
    longint        br;
    longint        bi;
    longint        den;
    r = '0;
    sat = 1'b0;
    ar = op.a_re;
    ai = op.a_im;
    br = op.b_re;
    bi = op.b_im;
    case (op.kind)
      cfa_pkg::OP_ADD: begin
        r.re = sat_part(ar + br, sat);
        r.im = sat_part(ai + bi, sat);
      end
      cfa_pkg::OP_SUB: begin
        r.re = sat_part(ar - br, sat);
        r.im = sat_part(ai - bi, sat);
      end
      cfa_pkg::OP_MUL: begin
        // arithmetic shift of the exact sum rounds toward minus infinity
        r.re = sat_part((ar * br - ai * bi) >>> FRAC, sat);
        r.im = sat_part((ar * bi + ai * br) >>> FRAC, sat);
      end
      cfa_pkg::OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = cfa_pkg::ST_DIVZ;
        end else begin
          r.re = sat_part(quot_trunc(ar * br + ai * bi, den), sat);
          r.im = sat_part(quot_trunc(ai * br - ar * bi, den), sat);
        end
      end
      cfa_pkg::OP_EQ: begin
        r.eq = (ar == br) && (ai == bi);
      end
      default: ;
    endcase
    if (sat && r.status == cfa_pkg::ST_OK) r.status = cfa_pkg::ST_SAT;
    return r;
  endfunction

  function automatic logic signed [W-1:0] random_part();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 65535);
      4, 5, 6:    v = $urandom_range(0, 2047) - 1024;
      7:          v = $urandom_range(0, 255) - 128;
      default: begin
        case ($urandom_range(0, 4))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
    endcase
    return v[W-1:0];
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t op;
    if ($urandom_range(0, 99) < 94)
      op.kind = 3'($urandom_range(cfa_pkg::OP_ADD, cfa_pkg::OP_EQ));
    else op.kind = 3'($urandom_range(cfa_pkg::OP_EQ + 1, OP_LAST));
    op.a_re = random_part();
    op.a_im = random_part();
    op.b_re = random_part();
    op.b_im = random_part();
    if (op.kind == cfa_pkg::OP_EQ && $urandom_range(0, 2) != 0) begin
      op.b_re = op.a_re;
      if ($urandom_range(0, 3) != 0) op.b_im = op.a_im;
    end
    if (op.kind == cfa_pkg::OP_DIV && $urandom_range(0, 19) == 0) begin
      op.b_re = '0;
      op.b_im = '0;
    end
    return op;
  endfunction

  task automatic queue_op(logic [2:0] kind, int ar, int ai, int br, int bi);
    alu_op_t op;
    op.kind = kind;
    op.a_re = ar[W-1:0];
    op.a_im = ai[W-1:0];
    op.b_re = br[W-1:0];
    op.b_im = bi[W-1:0];
    ops_to_send.push_back(op);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: record each accepted beat with its prediction, then draw a gap
  // before presenting the next operation.
  always @(posedge clk) begin : driver
    alu_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = -1;
    end else begin
      if (in_valid && in_ready) begin
        op = '{in_kind, in_a_re, in_a_im, in_b_re, in_b_im};
        results_due.push_back('{op, alu_expected(op)});
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap < 0) send_gap = (beats_in % 300 < 60) ? 0 : $urandom_range(0, 8);
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (hold_sender || ops_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          op = ops_to_send.pop_front();
          in_valid <= 1'b1;
          in_kind  <= op.kind;
          in_a_re  <= op.a_re;
          in_a_im  <= op.a_im;
          in_b_re  <= op.b_re;
          in_b_im  <= op.b_im;
          send_gap = -1;
        end
      end
    end
  end

  // Receiver: compare each result beat with the oldest prediction, then draw a stall gap.
  always @(posedge clk) begin : monitor
    alu_due_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap = -1;
    end else begin
      if (out_valid && out_ready) begin
        recv_gap = -1;
        beats_out++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: re %0d im %0d eq %0d status %0d",
                     out_res_re, out_res_im, out_equal_flag, out_status);
        end else begin
          want = results_due.pop_front();
          if (out_res_re !== want.res.re || out_res_im !== want.res.im ||
              out_equal_flag !== want.res.eq || out_status !== want.res.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch: kind %0d a (%0d,%0d) b (%0d,%0d): ",
                     want.op.kind, want.op.a_re, want.op.a_im, want.op.b_re,
                     want.op.b_im);
              $write("expected re %0d im %0d eq %0d status %0d, ",
                     want.res.re, want.res.im, want.res.eq, want.res.status);
              $display("got re %0d im %0d eq %0d status %0d",
                       out_res_re, out_res_im, out_equal_flag, out_status);
            end
          end
        end
      end
      if (recv_gap < 0) recv_gap = (beats_out % 250 < 50) ? 0 : $urandom_range(0, 8);
      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n_directed;
    rst_n = 1'b0;
    hold_sender = 1'b0;

    // saturating and exact-limit sums
    queue_op(cfa_pkg::OP_ADD, 32767, 32767, 32767, 1);
    queue_op(cfa_pkg::OP_ADD, -32768, -32768, -32768, -1);
    queue_op(cfa_pkg::OP_ADD, -16384, 256, -16384, -256);
    queue_op(cfa_pkg::OP_SUB, -32768, 32767, 32767, -32768);
    queue_op(cfa_pkg::OP_SUB, 300, -5, 300, -5);
    // products: unity, floor of negatives, overflow of each part
    queue_op(cfa_pkg::OP_MUL, 256, 0, 256, 0);
    queue_op(cfa_pkg::OP_MUL, -1, 0, 1, 0);
    queue_op(cfa_pkg::OP_MUL, 384, -640, -128, 896);
    queue_op(cfa_pkg::OP_MUL, -32768, -32768, -32768, -32768);
    queue_op(cfa_pkg::OP_MUL, 32767, -32768, 32767, 32767);
    // quotients: zero divisor, unity, truncation, overflow, extreme divisor
    queue_op(cfa_pkg::OP_DIV, 1000, -1000, 0, 0);
    queue_op(cfa_pkg::OP_DIV, 0, 0, 0, 0);
    queue_op(cfa_pkg::OP_DIV, 256, 0, 256, 0);
    queue_op(cfa_pkg::OP_DIV, -256, 0, 768, 0);
    queue_op(cfa_pkg::OP_DIV, 32767, 32767, 1, 0);
    queue_op(cfa_pkg::OP_DIV, -32768, 32767, -32768, -32768);
    queue_op(cfa_pkg::OP_DIV, 500, -700, 3, -2);
    // equality: match, imaginary mismatch, extremes
    queue_op(cfa_pkg::OP_EQ, 1234, -77, 1234, -77);
    queue_op(cfa_pkg::OP_EQ, 1234, -77, 1234, -78);
    queue_op(cfa_pkg::OP_EQ, -32768, 32767, -32768, 32767);
    // unused codes
    for (int k = cfa_pkg::OP_EQ + 1; k <= OP_LAST; k++)
      queue_op(3'(k), 32767, -32768, 5, -5);
    n_directed = ops_to_send.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // drain the directed set completely before the random part
    while (ops_to_send.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);

    repeat (N_RANDOM) ops_to_send.push_back(random_op());

    // hold off the sender midway until everything in flight has come back
    while (beats_in < n_directed + N_RANDOM / 2) @(negedge clk);
    hold_sender = 1'b1;
    while (in_valid || results_due.size() != 0) @(negedge clk);
    hold_sender = 1'b0;

    while (ops_to_send.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/cfa_pkg.sv
sv/complex_fixed_point_alu.sv
verif/tb.sv
